[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers. Define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/core/i2cms_pkg.sv]
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants of the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    // Command codes; codes 6 and 7 carry no meaning and act as an idle tick
    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_SEND  = 3'd3,
        CMD_ACK   = 3'd4,
        CMD_READ  = 3'd5
    } cmd_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_START_STOP_WAIT = 3'd0;
    localparam logic [2:0] CFG_WRITE_HALF_WAIT = 3'd1;
    localparam logic [2:0] CFG_READ_HALF_WAIT  = 3'd2;
    localparam logic [2:0] CFG_ACK_SETTLE_WAIT = 3'd3;
    localparam logic [2:0] CFG_ACK_TIMEOUT     = 3'd4;

    // Configuration reset values
    localparam logic [7:0] RST_START_STOP_WAIT = 8'd4;
    localparam logic [7:0] RST_WRITE_HALF_WAIT = 8'd2;
    localparam logic [7:0] RST_READ_HALF_WAIT  = 8'd100;
    localparam logic [7:0] RST_ACK_SETTLE_WAIT = 8'd3;
    localparam logic [7:0] RST_ACK_TIMEOUT     = 8'd250;

    // Sequence phases
    localparam logic [2:0] PH_FIRST  = 3'd0;
    localparam logic [2:0] PH_SECOND = 3'd1;
    localparam logic [2:0] PH_THIRD  = 3'd2;
    localparam logic [2:0] PH_FOURTH = 3'd3;

    localparam logic [3:0] BIT_LAST = 4'd7;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] tx_data;
        logic       send_ack;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_missing;
    } out_item_t;

    typedef struct packed {
        logic [7:0] start_stop_wait;
        logic [7:0] write_half_wait;
        logic [7:0] read_half_wait;
        logic [7:0] ack_settle_wait;
        logic [7:0] ack_timeout;
    } cfg_t;

    typedef struct packed {
        cmd_t       active_cmd;
        logic [2:0] phase;
        logic [3:0] bit_index;
        logic [7:0] wait_count;
        logic [7:0] poll_count;
        logic [7:0] shift_byte;
        logic       scl;
        logic       sda;
        logic       sda_dir;
        logic       ack_flag;
        logic [7:0] rx_hold;
        logic       ack_choice;
    } seq_state_t;

endpackage

[rtl/core/i2cms_step.sv]
// ----------------------------------------------------------------------------
// i2cms_step
// Next-state logic for one timer tick: accept a command, count down the
// phase delay, advance the sequence, shift bits and poll the slave ACK.
// ----------------------------------------------------------------------------
module i2cms_step (
    input  i2cms_pkg::seq_state_t state,
    input  i2cms_pkg::in_item_t   item,
    input  i2cms_pkg::cfg_t       cfg,
    output i2cms_pkg::seq_state_t state_next,
    output i2cms_pkg::out_item_t  result
);

    // A zero wait behaves as one tick
    function automatic logic [7:0] load_wait(input logic [7:0] w);
        return (w == 8'd0) ? 8'd1 : w;
    endfunction

    i2cms_pkg::seq_state_t n;
    logic                  done;
    logic [7:0]            wait_dec;

    always_comb
    begin
        n        = state;
        done     = 1'b0;
        wait_dec = (state.wait_count != 8'd0) ? state.wait_count - 8'd1 : 8'd0;

        if (state.active_cmd == i2cms_pkg::CMD_IDLE)
        begin
            case (item.cmd)
                i2cms_pkg::CMD_START:
                begin
                    n.active_cmd = i2cms_pkg::CMD_START;
                    n.sda_dir    = 1'b1;
                    n.sda        = 1'b1;
                    n.scl        = 1'b1;
                    n.phase      = i2cms_pkg::PH_FIRST;
                    n.wait_count = load_wait(cfg.start_stop_wait);
                end
                i2cms_pkg::CMD_STOP:
                begin
                    n.active_cmd = i2cms_pkg::CMD_STOP;
                    n.sda_dir    = 1'b1;
                    n.scl        = 1'b0;
                    n.sda        = 1'b0;
                    n.phase      = i2cms_pkg::PH_FIRST;
                    n.wait_count = load_wait(cfg.start_stop_wait);
                end
                i2cms_pkg::CMD_SEND:
                begin
                    n.active_cmd = i2cms_pkg::CMD_SEND;
                    n.sda_dir    = 1'b1;
                    n.scl        = 1'b0;
                    n.bit_index  = 4'd0;
                    n.sda        = item.tx_data[7];
                    n.shift_byte = {item.tx_data[6:0], 1'b0};
                    n.phase      = i2cms_pkg::PH_FIRST;
                    n.wait_count = load_wait(cfg.write_half_wait);
                end
                i2cms_pkg::CMD_ACK:
                begin
                    n.active_cmd = i2cms_pkg::CMD_ACK;
                    n.sda_dir    = 1'b0;
                    n.scl        = 1'b1;
                    n.poll_count = 8'd0;
                    n.ack_flag   = 1'b0;
                    n.phase      = i2cms_pkg::PH_FIRST;
                    n.wait_count = load_wait(cfg.ack_settle_wait);
                end
                i2cms_pkg::CMD_READ:
                begin
                    n.active_cmd = i2cms_pkg::CMD_READ;
                    n.sda_dir    = 1'b0;
                    n.scl        = 1'b0;
                    n.shift_byte = 8'd0;
                    n.bit_index  = 4'd0;
                    n.ack_choice = item.send_ack;
                    n.phase      = i2cms_pkg::PH_FIRST;
                    n.wait_count = load_wait(cfg.read_half_wait);
                end
                default:
                begin
                end
            endcase
        end
        else if ((state.active_cmd == i2cms_pkg::CMD_ACK && state.phase == i2cms_pkg::PH_SECOND)
                 || wait_dec == 8'd0)
        begin
            // Polling ACK skips the delay countdown entirely
            if (!(state.active_cmd == i2cms_pkg::CMD_ACK
                  && state.phase == i2cms_pkg::PH_SECOND))
            begin
                n.wait_count = wait_dec;
            end

            case (state.active_cmd)
                i2cms_pkg::CMD_START:
                begin
                    if (state.phase == i2cms_pkg::PH_FIRST)
                    begin
                        n.sda        = 1'b0;
                        n.phase      = i2cms_pkg::PH_SECOND;
                        n.wait_count = load_wait(cfg.start_stop_wait);
                    end
                    else
                    begin
                        n.scl        = 1'b0;
                        n.active_cmd = i2cms_pkg::CMD_IDLE;
                        n.phase      = i2cms_pkg::PH_FIRST;
                        done         = 1'b1;
                    end
                end
                i2cms_pkg::CMD_STOP:
                begin
                    if (state.phase == i2cms_pkg::PH_FIRST)
                    begin
                        n.scl        = 1'b1;
                        n.sda        = 1'b1;
                        n.phase      = i2cms_pkg::PH_SECOND;
                        n.wait_count = load_wait(cfg.start_stop_wait);
                    end
                    else
                    begin
                        n.active_cmd = i2cms_pkg::CMD_IDLE;
                        n.phase      = i2cms_pkg::PH_FIRST;
                        done         = 1'b1;
                    end
                end
                i2cms_pkg::CMD_SEND:
                begin
                    if (state.phase == i2cms_pkg::PH_FIRST)
                    begin
                        n.scl        = 1'b1;
                        n.phase      = i2cms_pkg::PH_SECOND;
                        n.wait_count = load_wait(cfg.write_half_wait);
                    end
                    else if (state.phase == i2cms_pkg::PH_SECOND)
                    begin
                        n.scl        = 1'b0;
                        n.phase      = i2cms_pkg::PH_THIRD;
                        n.wait_count = load_wait(cfg.write_half_wait);
                    end
                    else if (state.bit_index >= i2cms_pkg::BIT_LAST)
                    begin
                        n.active_cmd = i2cms_pkg::CMD_IDLE;
                        n.phase      = i2cms_pkg::PH_FIRST;
                        done         = 1'b1;
                    end
                    else
                    begin
                        n.bit_index  = state.bit_index + 4'd1;
                        n.sda        = state.shift_byte[7];
                        n.shift_byte = {state.shift_byte[6:0], 1'b0};
                        n.phase      = i2cms_pkg::PH_FIRST;
                        n.wait_count = load_wait(cfg.write_half_wait);
                    end
                end
                i2cms_pkg::CMD_ACK:
                begin
                    n.phase = i2cms_pkg::PH_SECOND;
                    if (!item.sda_in)
                    begin
                        n.scl        = 1'b0;
                        n.ack_flag   = 1'b0;
                        n.active_cmd = i2cms_pkg::CMD_IDLE;
                        n.phase      = i2cms_pkg::PH_FIRST;
                        done         = 1'b1;
                    end
                    else if (state.poll_count >= cfg.ack_timeout)
                    begin
                        // No ACK: flag it and run a stop sequence
                        n.ack_flag   = 1'b1;
                        n.active_cmd = i2cms_pkg::CMD_STOP;
                        n.sda_dir    = 1'b1;
                        n.scl        = 1'b0;
                        n.sda        = 1'b0;
                        n.phase      = i2cms_pkg::PH_FIRST;
                        n.wait_count = load_wait(cfg.start_stop_wait);
                    end
                    else
                    begin
                        n.poll_count = state.poll_count + 8'd1;
                    end
                end
                i2cms_pkg::CMD_READ:
                begin
                    if (state.phase == i2cms_pkg::PH_FIRST)
                    begin
                        n.scl        = 1'b1;
                        n.shift_byte = {state.shift_byte[6:0], item.sda_in};
                        n.phase      = i2cms_pkg::PH_SECOND;
                        n.wait_count = load_wait(cfg.read_half_wait);
                    end
                    else if (state.phase == i2cms_pkg::PH_SECOND)
                    begin
                        n.scl = 1'b0;
                        if (state.bit_index >= i2cms_pkg::BIT_LAST)
                        begin
                            n.rx_hold    = state.shift_byte;
                            n.sda_dir    = 1'b1;
                            n.sda        = ~state.ack_choice;
                            n.phase      = i2cms_pkg::PH_THIRD;
                            n.wait_count = load_wait(cfg.write_half_wait);
                        end
                        else
                        begin
                            n.bit_index  = state.bit_index + 4'd1;
                            n.phase      = i2cms_pkg::PH_FIRST;
                            n.wait_count = load_wait(cfg.read_half_wait);
                        end
                    end
                    else if (state.phase == i2cms_pkg::PH_THIRD)
                    begin
                        n.scl        = 1'b1;
                        n.phase      = i2cms_pkg::PH_FOURTH;
                        n.wait_count = load_wait(cfg.write_half_wait);
                    end
                    else
                    begin
                        n.scl        = 1'b0;
                        n.active_cmd = i2cms_pkg::CMD_IDLE;
                        n.phase      = i2cms_pkg::PH_FIRST;
                        done         = 1'b1;
                    end
                end
                default:
                begin
                    n.active_cmd = i2cms_pkg::CMD_IDLE;
                    n.phase      = i2cms_pkg::PH_FIRST;
                    done         = 1'b1;
                end
            endcase
        end
        else
        begin
            n.wait_count = wait_dec;
        end
    end

    assign state_next = n;

    always_comb
    begin
        result.scl_level   = n.scl;
        result.sda_level   = n.sda_dir ? n.sda : 1'b1;
        result.sda_drive   = n.sda_dir;
        result.busy_res    = (n.active_cmd != i2cms_pkg::CMD_IDLE);
        result.done_res    = done;
        result.rx_byte     = n.rx_hold;
        result.ack_missing = n.ack_flag;
    end

endmodule

[rtl/core/i2c_master_bit_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_unit
// I2C master line sequencer: start, stop, byte send, ACK wait and byte read.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data): one transfer per timer tick,
//   carrying the sampled SDA level and an optional command. Commands that
//   arrive while a sequence is running are ignored.
//   Output channel (out_valid/out_ready/out_data): one transfer per input,
//   showing SCL/SDA drive levels, busy, a done pulse, the last read byte and
//   the missing-ACK flag as they stand after that tick.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 start/
//   stop wait, 1 write half wait, 2 read half wait, 3 ACK settle wait,
//   4 ACK timeout); write only while idle.
//   The output is registered and valid in the cycle after the input
//   transfer. Throughput: one tick per clock, set by the single next-state
//   stage feeding the result register; in_ready stays high while the result
//   register is empty or being drained in the same cycle.
//   Reset: lines high and driven, sequencer idle, registers at defaults.
//   A stalled receiver holds the result and drops in_ready until it drains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_master_bit_sequencer_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  i2cms_pkg::in_item_t    in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output i2cms_pkg::out_item_t   out_data,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [7:0]             cfg_data
);

    i2cms_pkg::cfg_t       cfg_reg;
    i2cms_pkg::seq_state_t state_reg;
    i2cms_pkg::seq_state_t state_next;
    i2cms_pkg::out_item_t  result_next;
    i2cms_pkg::out_item_t  out_data_reg;
    logic                  out_valid_reg;
    logic                  in_fire;

    // Take a new tick whenever the result slot is free or draining now
    assign in_ready = ~out_valid_reg | out_ready;
    assign in_fire  = in_valid & in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_stop_wait <= i2cms_pkg::RST_START_STOP_WAIT;
            cfg_reg.write_half_wait <= i2cms_pkg::RST_WRITE_HALF_WAIT;
            cfg_reg.read_half_wait  <= i2cms_pkg::RST_READ_HALF_WAIT;
            cfg_reg.ack_settle_wait <= i2cms_pkg::RST_ACK_SETTLE_WAIT;
            cfg_reg.ack_timeout     <= i2cms_pkg::RST_ACK_TIMEOUT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                i2cms_pkg::CFG_START_STOP_WAIT: cfg_reg.start_stop_wait <= cfg_data;
                i2cms_pkg::CFG_WRITE_HALF_WAIT: cfg_reg.write_half_wait <= cfg_data;
                i2cms_pkg::CFG_READ_HALF_WAIT:  cfg_reg.read_half_wait  <= cfg_data;
                i2cms_pkg::CFG_ACK_SETTLE_WAIT: cfg_reg.ack_settle_wait <= cfg_data;
                i2cms_pkg::CFG_ACK_TIMEOUT:     cfg_reg.ack_timeout     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Per-tick sequencing logic
    i2cms_step u_step (
        .state      (state_reg),
        .item       (in_data),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Sequencer state: advance only on an accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.active_cmd <= i2cms_pkg::CMD_IDLE;
            state_reg.phase      <= i2cms_pkg::PH_FIRST;
            state_reg.bit_index  <= 4'd0;
            state_reg.wait_count <= 8'd0;
            state_reg.poll_count <= 8'd0;
            state_reg.shift_byte <= 8'd0;
            state_reg.scl        <= 1'b1;
            state_reg.sda        <= 1'b1;
            state_reg.sda_dir    <= 1'b1;
            state_reg.ack_flag   <= 1'b0;
            state_reg.rx_hold    <= 8'd0;
            state_reg.ack_choice <= 1'b0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result register: hold the valid flag until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A finished command always leaves the sequencer idle
    `ASSERT_SAME(a_done_not_busy, clk, rst_n,
        out_valid_reg && out_data_reg.done_res, !out_data_reg.busy_res,
        "done pulse while still busy")

    // Idle sequencer always parks in the first phase
    `ASSERT_SAME(a_idle_phase, clk, rst_n,
        state_reg.active_cmd == i2cms_pkg::CMD_IDLE,
        state_reg.phase == i2cms_pkg::PH_FIRST,
        "idle sequencer with nonzero phase")

    // A start accepted while idle must launch the start sequence
    `ASSERT_NEXT(a_start_launch, clk, rst_n,
        in_fire && state_reg.active_cmd == i2cms_pkg::CMD_IDLE
            && in_data.cmd == i2cms_pkg::CMD_START,
        state_reg.active_cmd == i2cms_pkg::CMD_START && out_data_reg.busy_res,
        "start command not launched")

endmodule
